// File: hdl/cafeu_pkg.sv
// Shared types, operation codes and flag positions for the 6502-style execute unit.
`default_nettype none

package cafeu_pkg;

    // Operation codes
    localparam logic [5:0] OP_ADC = 6'd0;
    localparam logic [5:0] OP_AND = 6'd1;
    localparam logic [5:0] OP_EOR = 6'd2;
    localparam logic [5:0] OP_ORA = 6'd3;
    localparam logic [5:0] OP_ASL = 6'd4;
    localparam logic [5:0] OP_LSR = 6'd5;
    localparam logic [5:0] OP_ROL = 6'd6;
    localparam logic [5:0] OP_ROR = 6'd7;
    localparam logic [5:0] OP_BIT = 6'd8;
    localparam logic [5:0] OP_CMP = 6'd9;
    localparam logic [5:0] OP_CPX = 6'd10;
    localparam logic [5:0] OP_CPY = 6'd11;
    localparam logic [5:0] OP_DEC = 6'd12;
    localparam logic [5:0] OP_INC = 6'd13;
    localparam logic [5:0] OP_DEX = 6'd14;
    localparam logic [5:0] OP_DEY = 6'd15;
    localparam logic [5:0] OP_INX = 6'd16;
    localparam logic [5:0] OP_INY = 6'd17;
    localparam logic [5:0] OP_LDA = 6'd18;
    localparam logic [5:0] OP_LDX = 6'd19;
    localparam logic [5:0] OP_LDY = 6'd20;
    localparam logic [5:0] OP_CLC = 6'd21;
    localparam logic [5:0] OP_CLI = 6'd22;
    localparam logic [5:0] OP_CLV = 6'd23;
    localparam logic [5:0] OP_CLD = 6'd24;
    localparam logic [5:0] OP_NOP = 6'd25;
    localparam logic [5:0] OP_BCC = 6'd26;
    localparam logic [5:0] OP_BCS = 6'd27;
    localparam logic [5:0] OP_BEQ = 6'd28;
    localparam logic [5:0] OP_BMI = 6'd29;
    localparam logic [5:0] OP_BNE = 6'd30;
    localparam logic [5:0] OP_BPL = 6'd31;
    localparam logic [5:0] OP_BVC = 6'd32;
    localparam logic [5:0] OP_BVS = 6'd33;
    localparam logic [5:0] OP_JMP = 6'd34;

    // Status bit positions (N V 1 B D I Z C)
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Bit 5 always reads as one on the status output
    localparam logic [7:0] STATUS_ONE = 8'h20;

    // Added cycle counts for branches
    localparam logic [1:0] EXTRA_NONE  = 2'd0;
    localparam logic [1:0] EXTRA_TAKEN = 2'd1;
    localparam logic [1:0] EXTRA_PAGE  = 2'd2;

    // Architectural register file
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
    } t_regs;

    // Program counter outcome from the branch unit
    typedef struct packed {
        logic [15:0] next_pc;
        logic        taken;
        logic [1:0]  extra;
    } t_pc_res;

    // Memory write-back from the ALU
    typedef struct packed {
        logic [7:0] data;
        logic       write;
    } t_mem_res;

endpackage

`default_nettype wire

// File: hdl/cafeu_alu.sv
// Data path of the execute unit: arithmetic, logic, shifts, compares and flag updates.
`default_nettype none

module cafeu_alu
    import cafeu_pkg::*;
(
    input  wire logic [5:0] i_op,
    input  wire logic [7:0] i_operand,
    input  wire logic       i_to_memory,
    input  wire t_regs      i_regs,
    output t_regs           o_regs,
    output t_mem_res        o_mem
);

    logic [8:0] sum;
    logic [8:0] cmp_diff;
    logic [7:0] cmp_reg;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_cout;
    logic [7:0] nz_val;
    logic       nz_upd;
    logic       carry_in;

    assign carry_in = i_regs.p[FLAG_C];

    // Add with carry
    assign sum = {1'b0, i_regs.acc} + {1'b0, i_operand} + {8'd0, carry_in};

    // Compare source and subtraction; borrow out means register < data
    always_comb begin
        case (i_op)
            OP_CPX:  cmp_reg = i_regs.x;
            OP_CPY:  cmp_reg = i_regs.y;
            default: cmp_reg = i_regs.acc;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, i_operand};

    // Shifter shared by ASL/LSR/ROL/ROR
    assign sh_src = i_to_memory ? i_operand : i_regs.acc;
    always_comb begin
        case (i_op)
            OP_ASL: begin
                sh_res  = {sh_src[6:0], 1'b0};
                sh_cout = sh_src[7];
            end
            OP_LSR: begin
                sh_res  = {1'b0, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
            OP_ROL: begin
                sh_res  = {sh_src[6:0], carry_in};
                sh_cout = sh_src[7];
            end
            default: begin
                sh_res  = {carry_in, sh_src[7:1]};
                sh_cout = sh_src[0];
            end
        endcase
    end

    // Register and flag updates per operation
    always_comb begin
        o_regs = i_regs;
        o_mem  = '0;
        nz_val = 8'd0;
        nz_upd = 1'b0;
        case (i_op)
            OP_ADC: begin
                o_regs.acc         = sum[7:0];
                o_regs.p[FLAG_C]   = sum[8];
                o_regs.p[FLAG_V]   = ~(i_regs.acc[7] ^ i_operand[7])
                                     & (i_regs.acc[7] ^ sum[7]);
                nz_val = sum[7:0];
                nz_upd = 1'b1;
            end
            OP_AND: begin
                o_regs.acc = i_regs.acc & i_operand;
                nz_val = i_regs.acc & i_operand;
                nz_upd = 1'b1;
            end
            OP_EOR: begin
                o_regs.acc = i_regs.acc ^ i_operand;
                nz_val = i_regs.acc ^ i_operand;
                nz_upd = 1'b1;
            end
            OP_ORA: begin
                o_regs.acc = i_regs.acc | i_operand;
                nz_val = i_regs.acc | i_operand;
                nz_upd = 1'b1;
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                o_regs.p[FLAG_C] = sh_cout;
                nz_val = sh_res;
                nz_upd = 1'b1;
                if (i_to_memory) begin
                    o_mem.data  = sh_res;
                    o_mem.write = 1'b1;
                end else begin
                    o_regs.acc = sh_res;
                end
            end
            OP_BIT: begin
                o_regs.p[FLAG_Z] = ((i_regs.acc & i_operand) == 8'd0);
                o_regs.p[FLAG_V] = i_operand[6];
                o_regs.p[FLAG_N] = i_operand[7];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                o_regs.p[FLAG_C] = ~cmp_diff[8];
                nz_val = cmp_diff[7:0];
                nz_upd = 1'b1;
            end
            OP_DEC: begin
                o_mem.data  = i_operand - 8'd1;
                o_mem.write = 1'b1;
                nz_val = i_operand - 8'd1;
                nz_upd = 1'b1;
            end
            OP_INC: begin
                o_mem.data  = i_operand + 8'd1;
                o_mem.write = 1'b1;
                nz_val = i_operand + 8'd1;
                nz_upd = 1'b1;
            end
            OP_DEX: begin
                o_regs.x = i_regs.x - 8'd1;
                nz_val = i_regs.x - 8'd1;
                nz_upd = 1'b1;
            end
            OP_DEY: begin
                o_regs.y = i_regs.y - 8'd1;
                nz_val = i_regs.y - 8'd1;
                nz_upd = 1'b1;
            end
            OP_INX: begin
                o_regs.x = i_regs.x + 8'd1;
                nz_val = i_regs.x + 8'd1;
                nz_upd = 1'b1;
            end
            OP_INY: begin
                o_regs.y = i_regs.y + 8'd1;
                nz_val = i_regs.y + 8'd1;
                nz_upd = 1'b1;
            end
            OP_LDA: begin
                o_regs.acc = i_operand;
                nz_val = i_operand;
                nz_upd = 1'b1;
            end
            OP_LDX: begin
                o_regs.x = i_operand;
                nz_val = i_operand;
                nz_upd = 1'b1;
            end
            OP_LDY: begin
                o_regs.y = i_operand;
                nz_val = i_operand;
                nz_upd = 1'b1;
            end
            OP_CLC: o_regs.p[FLAG_C] = 1'b0;
            OP_CLI: o_regs.p[FLAG_I] = 1'b0;
            OP_CLV: o_regs.p[FLAG_V] = 1'b0;
            // CLD, NOP, branches, JMP and unused codes leave the registers alone
            default: ;
        endcase

        // Common N/Z update
        if (nz_upd) begin
            o_regs.p[FLAG_Z] = (nz_val == 8'd0);
            o_regs.p[FLAG_N] = nz_val[7];
        end
    end

endmodule

`default_nettype wire

// File: hdl/cafeu_branch.sv
// Branch and jump resolution: condition test, target add and page-cross cycle count.
`default_nettype none

module cafeu_branch
    import cafeu_pkg::*;
(
    input  wire logic [5:0]  i_op,
    input  wire logic [7:0]  i_operand,
    input  wire logic [15:0] i_pc_in,
    input  wire logic [15:0] i_jump_address,
    input  wire logic [7:0]  i_status,
    output t_pc_res          o_pc
);

    logic        cond;
    logic        is_branch;
    logic [15:0] target;

    // Flag test per branch opcode
    always_comb begin
        is_branch = 1'b1;
        case (i_op)
            OP_BCC:  cond = ~i_status[FLAG_C];
            OP_BCS:  cond =  i_status[FLAG_C];
            OP_BEQ:  cond =  i_status[FLAG_Z];
            OP_BMI:  cond =  i_status[FLAG_N];
            OP_BNE:  cond = ~i_status[FLAG_Z];
            OP_BPL:  cond = ~i_status[FLAG_N];
            OP_BVC:  cond = ~i_status[FLAG_V];
            OP_BVS:  cond =  i_status[FLAG_V];
            default: begin
                cond      = 1'b0;
                is_branch = 1'b0;
            end
        endcase
    end

    // Signed byte offset added to the next-instruction address
    assign target = i_pc_in + {{8{i_operand[7]}}, i_operand};

    always_comb begin
        o_pc.next_pc = i_pc_in;
        o_pc.taken   = 1'b0;
        o_pc.extra   = EXTRA_NONE;
        if (i_op == OP_JMP) begin
            o_pc.next_pc = i_jump_address;
            o_pc.taken   = 1'b1;
        end else if (is_branch && cond) begin
            o_pc.next_pc = target;
            o_pc.taken   = 1'b1;
            o_pc.extra   = (target[15:8] != i_pc_in[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
        end
    end

endmodule

`default_nettype wire

// File: hdl/cpu_alu_flag_execute_unit.sv
// Top level of the 6502-style execute unit: input register, ALU, branch unit, result register.
`default_nettype none

// Executes one decoded 6502-style operation per transfer on its own A, X, Y and P
// registers (all zero after reset). An accepted item is held in an input register, then
// passes through the ALU and branch logic into the result register, from which its
// result is presented; a new item is taken every cycle while results are drained.
// Register state commits as the item leaves the input
// register, so back-to-back items see each other's results. The status output always
// shows bit 5 set; mem_write flags the byte for memory read-modify-write operations.
module cpu_alu_flag_execute_unit
    import cafeu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [5:0]  i_op,
    input  wire logic [7:0]  i_operand,
    input  wire logic        i_to_memory,
    input  wire logic [15:0] i_pc_in,
    input  wire logic [15:0] i_jump_address,
    // Result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_acc_out,
    output logic [7:0]       o_x_out,
    output logic [7:0]       o_y_out,
    output logic [7:0]       o_status_out,
    output logic [7:0]       o_mem_result,
    output logic             o_mem_write,
    output logic [15:0]      o_next_pc,
    output logic             o_branch_taken,
    output logic [1:0]       o_extra_cycles
);

    // Input register
    logic        r_in_valid;
    logic [5:0]  r_op;
    logic [7:0]  r_operand;
    logic        r_to_memory;
    logic [15:0] r_pc_in;
    logic [15:0] r_jump_address;

    // Architectural registers
    t_regs r_regs;
    t_regs n_regs;

    // Result register
    logic     r_out_valid;
    t_regs    r_out_regs;
    t_mem_res r_out_mem;
    t_pc_res  r_out_pc;

    t_mem_res alu_mem;
    t_pc_res  br_pc;
    logic     advance;
    logic     in_xfer;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    cafeu_alu u_alu (
        .i_op        (r_op),
        .i_operand   (r_operand),
        .i_to_memory (r_to_memory),
        .i_regs      (r_regs),
        .o_regs      (n_regs),
        .o_mem       (alu_mem)
    );

    cafeu_branch u_branch (
        .i_op           (r_op),
        .i_operand      (r_operand),
        .i_pc_in        (r_pc_in),
        .i_jump_address (r_jump_address),
        .i_status       (r_regs.p),
        .o_pc           (br_pc)
    );

    // Input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op           <= i_op;
            r_operand      <= i_operand;
            r_to_memory    <= i_to_memory;
            r_pc_in        <= i_pc_in;
            r_jump_address <= i_jump_address;
        end
    end

    // Architectural state commits when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (advance) begin
            r_regs <= n_regs;
        end
    end

    // Result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_regs <= n_regs;
            r_out_mem  <= alu_mem;
            r_out_pc   <= br_pc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_acc_out      = r_out_regs.acc;
    assign o_x_out        = r_out_regs.x;
    assign o_y_out        = r_out_regs.y;
    assign o_status_out   = r_out_regs.p | STATUS_ONE;
    assign o_mem_result   = r_out_mem.data;
    assign o_mem_write    = r_out_mem.write;
    assign o_next_pc      = r_out_pc.next_pc;
    assign o_branch_taken = r_out_pc.taken;
    assign o_extra_cycles = r_out_pc.extra;

endmodule

`default_nettype wire

// File: tb/sv/cpu_alu_flag_execute_unit_test.sv
// Self-checking testbench for the 6502-style execute unit: directed table, then random operations.
`timescale 1ns / 1ps

module cpu_alu_flag_execute_unit_test;
    import cafeu_pkg::*;

    // Selectors above JMP decode as no-ops
    localparam logic [5:0] OP_UNUSED_TOP = 6'd63;

    localparam int RANDOM_ITEMS = 500;
    localparam int MODE_SPAN    = 50;
    localparam int MAX_IDLE     = 8;
    localparam int DRAIN_CYCLES = 10;
    localparam int QUIET_LIMIT  = 400;
    localparam int MAX_REPORTS  = 60;

    // One decoded operation as presented on the input channel
    typedef struct packed {
        logic [5:0]  op;
        logic [7:0]  operand;
        logic        to_mem;
        logic [15:0] pc;
        logic [15:0] jaddr;
    } exec_item_t;

    // Register file, flags and side outputs after one operation
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] status;
        t_mem_res   mem;
        t_pc_res    flow;
    } exec_result_t;

    typedef struct {
        exec_item_t   stim;
        bit           typed;
        exec_result_t want;
    } table_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [5:0]  i_op;
    logic [7:0]  i_operand;
    logic        i_to_memory;
    logic [15:0] i_pc_in;
    logic [15:0] i_jump_address;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_acc_out;
    logic [7:0]  o_x_out;
    logic [7:0]  o_y_out;
    logic [7:0]  o_status_out;
    logic [7:0]  o_mem_result;
    logic        o_mem_write;
    logic [15:0] o_next_pc;
    logic        o_branch_taken;
    logic [1:0]  o_extra_cycles;

    // Architectural state as the checker sees it
    logic [7:0] arch_acc;
    logic [7:0] arch_x;
    logic [7:0] arch_y;
    logic [7:0] arch_p;

    exec_result_t pending_results[$];
    table_row_t   directed_rows[$];
    logic [7:0]   corner_bytes [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

    bit src_idle;
    bit snk_idle;
    int mismatches;
    int items_sent;
    int results_checked;
    int taken_count;
    int page_count;
    int mem_writes;

    cpu_alu_flag_execute_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_operand      (i_operand),
        .i_to_memory    (i_to_memory),
        .i_pc_in        (i_pc_in),
        .i_jump_address (i_jump_address),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_acc_out      (o_acc_out),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_status_out   (o_status_out),
        .o_mem_result   (o_mem_result),
        .o_mem_write    (o_mem_write),
        .o_next_pc      (o_next_pc),
        .o_branch_taken (o_branch_taken),
        .o_extra_cycles (o_extra_cycles)
    );

    always #6 i_clk = ~i_clk;

    // Flag helpers for the predictor
    function automatic void set_nz(input logic [7:0] v);
        arch_p[FLAG_Z] = (v == 8'h00);
        arch_p[FLAG_N] = v[7];
    endfunction

    function automatic void compare_reg(input logic [7:0] lhs, input logic [7:0] data);
        logic [7:0] diff;
        diff = lhs - data;
        arch_p[FLAG_C] = (lhs >= data);
        set_nz(diff);
    endfunction

    // Executes one operation on the checker's copy of the state
    function automatic exec_result_t execute_op(input exec_item_t it);
        exec_result_t r;
        logic [8:0]   sum;
        logic [7:0]   src;
        logic [7:0]   shifted;
        logic [15:0]  target;
        logic         carry_out;
        logic         cond;
        r = '0;
        r.flow.next_pc = it.pc;
        r.flow.extra = EXTRA_NONE;
        case (it.op)
            OP_ADC: begin
                sum = {1'b0, arch_acc} + {1'b0, it.operand} + {8'd0, arch_p[FLAG_C]};
                arch_p[FLAG_C] = sum[8];
                // signed overflow: operands agree in sign, sum does not
                arch_p[FLAG_V] = ~(arch_acc[7] ^ it.operand[7]) & (arch_acc[7] ^ sum[7]);
                arch_acc = sum[7:0];
                set_nz(arch_acc);
            end
            OP_AND: begin
                arch_acc = arch_acc & it.operand;
                set_nz(arch_acc);
            end
            OP_EOR: begin
                arch_acc = arch_acc ^ it.operand;
                set_nz(arch_acc);
            end
            OP_ORA: begin
                arch_acc = arch_acc | it.operand;
                set_nz(arch_acc);
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                src = it.to_mem ? it.operand : arch_acc;
                case (it.op)
                    OP_ASL: begin
                        carry_out = src[7];
                        shifted = {src[6:0], 1'b0};
                    end
                    OP_LSR: begin
                        carry_out = src[0];
                        shifted = {1'b0, src[7:1]};
                    end
                    OP_ROL: begin
                        carry_out = src[7];
                        shifted = {src[6:0], arch_p[FLAG_C]};
                    end
                    default: begin
                        carry_out = src[0];
                        shifted = {arch_p[FLAG_C], src[7:1]};
                    end
                endcase
                arch_p[FLAG_C] = carry_out;
                set_nz(shifted);
                if (it.to_mem) begin
                    r.mem.data = shifted;
                    r.mem.write = 1'b1;
                end else begin
                    arch_acc = shifted;
                end
            end
            OP_BIT: begin
                arch_p[FLAG_Z] = ((arch_acc & it.operand) == 8'h00);
                arch_p[FLAG_V] = it.operand[6];
                arch_p[FLAG_N] = it.operand[7];
            end
            OP_CMP: compare_reg(arch_acc, it.operand);
            OP_CPX: compare_reg(arch_x, it.operand);
            OP_CPY: compare_reg(arch_y, it.operand);
            OP_DEC, OP_INC: begin
                r.mem.data = (it.op == OP_DEC) ? it.operand - 8'd1 : it.operand + 8'd1;
                r.mem.write = 1'b1;
                set_nz(r.mem.data);
            end
            OP_DEX: begin
                arch_x = arch_x - 8'd1;
                set_nz(arch_x);
            end
            OP_DEY: begin
                arch_y = arch_y - 8'd1;
                set_nz(arch_y);
            end
            OP_INX: begin
                arch_x = arch_x + 8'd1;
                set_nz(arch_x);
            end
            OP_INY: begin
                arch_y = arch_y + 8'd1;
                set_nz(arch_y);
            end
            OP_LDA: begin
                arch_acc = it.operand;
                set_nz(arch_acc);
            end
            OP_LDX: begin
                arch_x = it.operand;
                set_nz(arch_x);
            end
            OP_LDY: begin
                arch_y = it.operand;
                set_nz(arch_y);
            end
            OP_CLC: arch_p[FLAG_C] = 1'b0;
            OP_CLI: arch_p[FLAG_I] = 1'b0;
            OP_CLV: arch_p[FLAG_V] = 1'b0;
            OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS: begin
                case (it.op)
                    OP_BCC:  cond = !arch_p[FLAG_C];
                    OP_BCS:  cond = arch_p[FLAG_C];
                    OP_BEQ:  cond = arch_p[FLAG_Z];
                    OP_BMI:  cond = arch_p[FLAG_N];
                    OP_BNE:  cond = !arch_p[FLAG_Z];
                    OP_BPL:  cond = !arch_p[FLAG_N];
                    OP_BVC:  cond = !arch_p[FLAG_V];
                    default: cond = arch_p[FLAG_V];
                endcase
                if (cond) begin
                    // offset is a signed byte, target wraps at 64K
                    target = it.pc + {{8{it.operand[7]}}, it.operand};
                    r.flow.next_pc = target;
                    r.flow.taken = 1'b1;
                    r.flow.extra = (target[15:8] != it.pc[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
                end
            end
            OP_JMP: begin
                r.flow.next_pc = it.jaddr;
                r.flow.taken = 1'b1;
            end
            default: ; // CLD, NOP and the unused selectors
        endcase
        r.acc = arch_acc;
        r.x = arch_x;
        r.y = arch_y;
        r.status = arch_p | STATUS_ONE;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at result %0d, %s: got %h, expected %h",
                     results_checked, field, got, want);
    endtask

    // Table entries checked against the predictor
    task automatic add_row(input logic [5:0] op, input logic [7:0] operand, input logic to_mem,
                           input logic [15:0] pc, input logic [15:0] jaddr);
        table_row_t row;
        row.stim = '{op, operand, to_mem, pc, jaddr};
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endtask

    // Table entries with the result written out by hand
    task automatic add_known(input logic [5:0] op, input logic [7:0] operand,
                             input logic to_mem, input logic [15:0] pc,
                             input logic [15:0] jaddr, input logic [7:0] acc,
                             input logic [7:0] x, input logic [7:0] y, input logic [7:0] st,
                             input logic [7:0] mem_data, input logic mem_wr,
                             input logic [15:0] npc, input logic tk, input logic [1:0] ex);
        table_row_t row;
        row.stim = '{op, operand, to_mem, pc, jaddr};
        row.typed = 1'b1;
        row.want.acc = acc;
        row.want.x = x;
        row.want.y = y;
        row.want.status = st;
        row.want.mem.data = mem_data;
        row.want.mem.write = mem_wr;
        row.want.flow.next_pc = npc;
        row.want.flow.taken = tk;
        row.want.flow.extra = ex;
        directed_rows.push_back(row);
    endtask

    // Input side: optional gap, then hold valid until the transfer
    task automatic send_item(input exec_item_t it, input bit typed, input exec_result_t want);
        int           gap;
        exec_result_t calc;
        gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= it.op;
        i_operand <= it.operand;
        i_to_memory <= it.to_mem;
        i_pc_in <= it.pc;
        i_jump_address <= it.jaddr;
        do @(posedge i_clk); while (!o_ready);
        calc = execute_op(it);
        pending_results.push_back(typed ? want : calc);
        items_sent++;
    endtask

    // Result side: random stalls, each transfer checked against the oldest expectation
    task automatic drain_results();
        int           stall;
        exec_result_t want;
        forever begin
            stall = snk_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 16'h0, 16'h0);
            end else begin
                want = pending_results.pop_front();
                if (o_acc_out !== want.acc)
                    report_mismatch("acc_out", 16'(o_acc_out), 16'(want.acc));
                if (o_x_out !== want.x)
                    report_mismatch("x_out", 16'(o_x_out), 16'(want.x));
                if (o_y_out !== want.y)
                    report_mismatch("y_out", 16'(o_y_out), 16'(want.y));
                if (o_status_out !== want.status)
                    report_mismatch("status_out", 16'(o_status_out), 16'(want.status));
                if (o_mem_result !== want.mem.data)
                    report_mismatch("mem_result", 16'(o_mem_result), 16'(want.mem.data));
                if (o_mem_write !== want.mem.write)
                    report_mismatch("mem_write", 16'(o_mem_write), 16'(want.mem.write));
                if (o_next_pc !== want.flow.next_pc)
                    report_mismatch("next_pc", o_next_pc, want.flow.next_pc);
                if (o_branch_taken !== want.flow.taken)
                    report_mismatch("branch_taken", 16'(o_branch_taken),
                                    16'(want.flow.taken));
                if (o_extra_cycles !== want.flow.extra)
                    report_mismatch("extra_cycles", 16'(o_extra_cycles),
                                    16'(want.flow.extra));
                taken_count += int'(want.flow.taken);
                page_count += int'(want.flow.extra == EXTRA_PAGE);
                mem_writes += int'(want.mem.write);
            end
            results_checked++;
        end
    endtask

    // Watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("cpu_alu_flag_execute_unit verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, random operations, drain
    initial begin : stimulus
        exec_item_t it;
        int         n;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_op = OP_NOP;
        i_operand = 8'h00;
        i_to_memory = 1'b0;
        i_pc_in = 16'h0000;
        i_jump_address = 16'h0000;
        arch_acc = 8'h00;
        arch_x = 8'h00;
        arch_y = 8'h00;
        arch_p = 8'h00;
        src_idle = 1'b1;
        snk_idle = 1'b1;

        // State right after reset, jump, unused selector, loads and memory inc/dec
        add_known(OP_NOP, 8'h00, 1'b0, 16'h0000, 16'h0000,
                  8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 1'b0, 16'h0000, 1'b0, EXTRA_NONE);
        add_known(OP_JMP, 8'hFF, 1'b1, 16'h1234, 16'hFFFF,
                  8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 1'b0, 16'hFFFF, 1'b1, EXTRA_NONE);
        add_known(OP_UNUSED_TOP, 8'hAA, 1'b1, 16'hFFFF, 16'h0000,
                  8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 1'b0, 16'hFFFF, 1'b0, EXTRA_NONE);
        add_known(OP_LDA, 8'hFF, 1'b0, 16'h0200, 16'h0000,
                  8'hFF, 8'h00, 8'h00, 8'hA0, 8'h00, 1'b0, 16'h0200, 1'b0, EXTRA_NONE);
        add_known(OP_INC, 8'hFF, 1'b0, 16'h0201, 16'h0000,
                  8'hFF, 8'h00, 8'h00, 8'h22, 8'h00, 1'b1, 16'h0201, 1'b0, EXTRA_NONE);
        add_known(OP_DEC, 8'h00, 1'b0, 16'h0202, 16'h0000,
                  8'hFF, 8'h00, 8'h00, 8'hA0, 8'hFF, 1'b1, 16'h0202, 1'b0, EXTRA_NONE);
        // carry out of FF, then carry in making signed overflow
        add_row(OP_ADC, 8'h01, 1'b0, 16'h0300, 16'h0000);
        add_row(OP_LDA, 8'h7F, 1'b0, 16'h0301, 16'h0000);
        add_row(OP_ADC, 8'h00, 1'b0, 16'h0302, 16'h0000);
        // backward branch across a page, forward within a page
        add_row(OP_BVS, 8'h80, 1'b0, 16'h0100, 16'h0000);
        add_row(OP_BMI, 8'h7F, 1'b0, 16'h0010, 16'h0000);
        add_row(OP_CLV, 8'h00, 1'b0, 16'h0400, 16'h0000);
        // branch wrapping below zero and above FFFF
        add_row(OP_BVC, 8'hFE, 1'b0, 16'h0001, 16'h0000);
        add_row(OP_AND, 8'h0F, 1'b0, 16'h0401, 16'h0000);
        add_row(OP_BEQ, 8'h01, 1'b0, 16'hFFFF, 16'h0000);
        add_row(OP_BNE, 8'h10, 1'b0, 16'h0402, 16'h0000);
        add_row(OP_EOR, 8'hFF, 1'b0, 16'h0403, 16'h0000);
        add_row(OP_ORA, 8'h00, 1'b0, 16'h0404, 16'h0000);
        // shifts and rotates on accumulator and memory
        add_row(OP_ASL, 8'h00, 1'b0, 16'h0405, 16'h0000);
        add_row(OP_ROL, 8'h80, 1'b1, 16'h0406, 16'h0000);
        add_row(OP_BCS, 8'h05, 1'b0, 16'h20FA, 16'h0000);
        add_row(OP_BCC, 8'h05, 1'b0, 16'h20FF, 16'h0000);
        add_row(OP_ROR, 8'h00, 1'b0, 16'h0500, 16'h0000);
        add_row(OP_LSR, 8'h01, 1'b1, 16'h0501, 16'h0000);
        add_row(OP_BIT, 8'hC0, 1'b0, 16'h0502, 16'h0000);
        add_row(OP_BPL, 8'h10, 1'b0, 16'h0503, 16'h0000);
        // compares, and the X register through its wrap points
        add_row(OP_CMP, 8'hFF, 1'b0, 16'h0504, 16'h0000);
        add_row(OP_LDX, 8'h00, 1'b0, 16'h0505, 16'h0000);
        add_row(OP_CPX, 8'h01, 1'b0, 16'h0506, 16'h0000);
        add_row(OP_DEX, 8'h00, 1'b0, 16'h0507, 16'h0000);
        add_row(OP_INX, 8'h00, 1'b0, 16'h0508, 16'h0000);
        add_row(OP_LDY, 8'h80, 1'b0, 16'h0509, 16'h0000);
        add_row(OP_CPY, 8'h7F, 1'b0, 16'h050A, 16'h0000);
        add_row(OP_INY, 8'h00, 1'b0, 16'h050B, 16'h0000);
        add_row(OP_DEY, 8'h00, 1'b0, 16'h050C, 16'h0000);
        // flag clears; decimal clear leaves everything alone
        add_row(OP_CLC, 8'h00, 1'b0, 16'h050D, 16'h0000);
        add_row(OP_CLI, 8'h00, 1'b0, 16'h050E, 16'h0000);
        add_row(OP_CLD, 8'hFF, 1'b1, 16'h050F, 16'hFFFF);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        foreach (directed_rows[k])
            send_item(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);

        // Hold off until the directed results are all back
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // idling pattern changes every span; one span runs at full rate
            if (n % MODE_SPAN == 0) begin
                src_idle = (n == MODE_SPAN) ? 1'b0 : 1'($urandom_range(0, 1));
                snk_idle = (n == MODE_SPAN) ? 1'b0 : 1'($urandom_range(0, 1));
            end
            if (n == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) == 0)
                it.op = 6'($urandom_range(OP_JMP + 1, OP_UNUSED_TOP));
            else
                it.op = 6'($urandom_range(OP_ADC, OP_JMP));
            if ($urandom_range(0, 4) == 0)
                it.operand = corner_bytes[$urandom_range(0, 3)];
            else
                it.operand = 8'($urandom_range(0, 255));
            it.to_mem = 1'($urandom_range(0, 1));
            it.pc = 16'($urandom_range(0, 65535));
            // bias some branch bases to the edges of a page
            if ($urandom_range(0, 3) == 0)
                it.pc[7:0] = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hFF))
                                                   : 8'($urandom_range(8'h00, 8'h0F));
            it.jaddr = 16'($urandom_range(0, 65535));
            send_item(it, 1'b0, '0);
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d operations and %0d checked results (%0d mismatches).",
                 items_sent, results_checked, mismatches);
        $display("Taken branches and jumps: %0d, of which page crossings: %0d; write-backs: %0d.",
                 taken_count, page_count, mem_writes);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("cpu_alu_flag_execute_unit verification clean");
        else
            $display("cpu_alu_flag_execute_unit verification failed");
        $finish;
    end

endmodule
